// ----- rtl/per_source_sequence_loss_tracker_top_assert.svh -----
// Assertion macros for the per-source sequence loss tracker.
`ifndef PER_SOURCE_SEQUENCE_LOSS_TRACKER_TOP_ASSERT_SVH
`define PER_SOURCE_SEQUENCE_LOSS_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle, skipped while reset is applied.
`define PSLT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pslt assertion failed");
// Implication checked in the cycle after the antecedent.
`define PSLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pslt assertion failed");
`else
`define PSLT_ASSERT(lbl, prop)
`define PSLT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/pslt_pkg.sv -----
// Shared constants and types of the per-source sequence loss tracker.
package pslt_pkg;

    localparam int NUM_SOURCES = 256;
    localparam int SRC_AW      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SRC_CMP_W   = 9;

    localparam int SEQ_W   = 8;
    localparam int CNT_W   = 32;
    localparam int RATE_W  = 10;

    // Dividend of the loss rate: lost * 1000 plus half the expected count.
    localparam int DVD_W    = 42;
    // The rounded rate never exceeds 1000, so eleven quotient bits suffice.
    localparam int DIV_Q_W  = 11;

    localparam logic [7:0]        JUMP_MAX_RESET     = 8'd64;
    localparam logic [15:0]       MIN_EXPECTED_RESET = 16'd32;
    localparam logic [RATE_W-1:0] PERMILLE_MAX       = 10'd1000;

    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_JUMP_MAX     = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MIN_EXPECTED = 2'd1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 120;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [SRC_AW-1:0] rd_addr;
        logic              wr_en;
        logic [SRC_AW-1:0] wr_addr;
        logic [SEQ_W-1:0]  wr_seq;
    } t_store_req;

    typedef struct packed {
        logic             seen;
        logic [SEQ_W-1:0] last_seq;
    } t_store_rsp;

endpackage

// ----- rtl/pslt_seq_store.sv -----
// Per-source store: seen flags in flip-flops and last sequence numbers in a RAM.
module pslt_seq_store
    import pslt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    logic [SEQ_W-1:0]       r_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_seen;
    logic [SEQ_W-1:0]       r_rd_seq;
    logic                   r_rd_seen;

    // Sequence RAM: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_seq;
        end
        if (i_req.rd_en) begin
            r_rd_seq <= r_mem[i_req.rd_addr];
        end
    end

    // Seen flags clear at once on reset and on a clear action.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_rd_seen <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_seen <= '0;
            end else if (i_req.wr_en) begin
                r_seen[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_seen <= r_seen[i_req.rd_addr];
            end
        end
    end

    assign o_rsp.seen     = r_rd_seen;
    assign o_rsp.last_seq = r_rd_seq;

endmodule

// ----- rtl/pslt_rate_div.sv -----
// Restoring divider for the loss rate, one quotient bit per cycle.
module pslt_rate_div
    import pslt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [CNT_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DIV_Q_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIV_Q_W + 1);

    logic [CNT_W-1:0]   r_rem,  n_rem;
    logic [DIV_Q_W-1:0] r_low,  n_low;
    logic [CNT_W-1:0]   r_div;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W:0]     w_trial;
    logic [CNT_W:0]     w_diff;
    logic               w_ge;

    // The quotient is known to fit in DIV_Q_W bits, so the upper dividend bits
    // start out as a remainder below the divisor.
    assign w_trial = {r_rem, r_low[DIV_Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_rem  = r_rem;
        n_low  = r_low;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = CNT_W'(i_dividend[DVD_W-1:DIV_Q_W]);
            n_low  = i_dividend[DIV_Q_W-1:0];
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            n_low  = {r_low[DIV_Q_W-2:0], w_ge};
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(DIV_Q_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_step <= n_step;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule

// ----- rtl/per_source_sequence_loss_tracker_top.sv -----
// Top level of the per-source sequence loss tracker.
// Input beats arrive on the s_axis channel: tuser carries the action (0 = frame
// received, 1 = clear session statistics) and tdata the source and sequence
// number. Each input beat yields exactly one result beat on m_axis carrying the
// gap counted for this frame, the lost, frame and expected totals and the loss
// rate in tenths of a percent.
// An item runs through these steps from acceptance to a valid result. The
// per-source RAM is read at the accepting edge. Then come the update and
// write-back, the 32 x 10 bit rate multiplication and the divider start, then
// the bit-serial restoring divider and the load of the output register.
// s_axis_tready returns as the result is loaded, so the block takes a new item
// only once the result of the last one is in the output register.
// The output register lets the next item be taken while a result waits; if the
// receiver still stalls when the next result is ready, the block holds it and
// keeps s_axis_tready low until the output register is free.
// Reset clears the seen flags, the counters and the output valid flag at once;
// no clearing pass is needed and the block is ready in the cycle after reset.
// The user must write jump_max and min_expected through i_cfg_* while the block idles; unchecked.
`include "per_source_sequence_loss_tracker_top_assert.svh"

module per_source_sequence_loss_tracker_top
    import pslt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [15:0]          i_cfg_wdata,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // source_id[7:0], seq_number[15:8]
    input  logic                 s_axis_tuser,  // action[0]
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // gap_counted[7:0], lost_total[39:8], frames_total[71:40],
    // expected_total[103:72], loss_permille[113:104], zero padding[119:114]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_UPD      = 6'b000010,
        S_MUL      = 6'b000100,
        S_DIV_GO   = 6'b001000,
        S_DIV_WAIT = 6'b010000,
        S_HOLD     = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [7:0]  r_jump_max;
    logic [15:0] r_min_exp;

    // Captured input item.
    logic             r_action;
    logic [7:0]       r_src;
    logic [SEQ_W-1:0] r_seq;

    // Session counters and per-item working values.
    logic [CNT_W-1:0]  r_lost, n_lost;
    logic [CNT_W-1:0]  r_frames, n_frames;
    logic [SEQ_W-1:0]  r_gap, n_gap;
    logic [CNT_W-1:0]  r_expected;
    logic [DVD_W-1:0]  r_prod;
    logic              r_rate_en;

    // Output register.
    logic              r_out_valid;
    logic [SEQ_W-1:0]  r_out_gap;
    logic [CNT_W-1:0]  r_out_lost;
    logic [CNT_W-1:0]  r_out_frames;
    logic [CNT_W-1:0]  r_out_expected;
    logic [RATE_W-1:0] r_out_permille;

    t_store_req w_req;
    t_store_rsp w_rsp;

    logic               w_accept;
    logic               w_in_range;
    logic [SEQ_W-1:0]   w_diff;
    logic [CNT_W:0]     w_sum;
    logic [CNT_W-1:0]   w_expected;
    logic [DVD_W-1:0]   w_dividend;
    logic               w_div_done;
    logic [DIV_Q_W-1:0] w_quot;
    logic               w_out_free;
    logic               w_load;
    logic [RATE_W-1:0]  w_permille;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // The state machine keeps one item in flight, so the write-back of one item
    // always lands before the RAM read of the next.
    assign s_axis_tready = (r_state == S_IDLE);

    assign w_in_range = {1'b0, r_src} < SRC_CMP_W'(NUM_SOURCES);
    assign w_diff     = r_seq - w_rsp.last_seq;

    // Gap evaluation, the clear action, the counter updates, the RAM read and the per-source write-back.
    always_comb begin
        w_req         = '0;
        w_req.rd_en   = w_accept;
        w_req.rd_addr = s_axis_tdata[SRC_AW-1:0];
        w_req.wr_addr = r_src[SRC_AW-1:0];
        w_req.wr_seq  = r_seq;
        n_lost        = r_lost;
        n_frames      = r_frames;
        n_gap         = '0;
        if (r_state == S_UPD) begin
            if (r_action) begin
                w_req.clear = 1'b1;
                n_lost      = '0;
                n_frames    = '0;
            end else begin
                if (w_in_range) begin
                    if (!w_rsp.seen) begin
                        w_req.wr_en = 1'b1;
                    end else if (w_diff != '0) begin
                        w_req.wr_en = 1'b1;
                        if (w_diff <= r_jump_max) begin
                            n_gap  = w_diff - SEQ_W'(1);
                            n_lost = r_lost + CNT_W'(n_gap);
                        end
                    end
                end
                n_frames = r_frames + CNT_W'(1);
            end
        end
    end

    // Expected count saturates at the top of the 32-bit range.
    assign w_sum      = {1'b0, r_frames} + {1'b0, r_lost};
    assign w_expected = w_sum[CNT_W] ? '1 : w_sum[CNT_W-1:0];
    assign w_dividend = r_prod + DVD_W'(r_expected[CNT_W-1:1]);

    pslt_seq_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    pslt_rate_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV_GO),
        .i_dividend (w_dividend),
        .i_divisor  (r_expected),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // The rate is zero when the expected count is zero or below the minimum, and never above 1000.
    always_comb begin
        if (!r_rate_en) begin
            w_permille = '0;
        end else if (w_quot > DIV_Q_W'(PERMILLE_MAX)) begin
            w_permille = PERMILLE_MAX;
        end else begin
            w_permille = w_quot[RATE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, session counters, configuration and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_jump_max  <= JUMP_MAX_RESET;
            r_min_exp   <= MIN_EXPECTED_RESET;
            r_lost      <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lost   <= n_lost;
            r_frames <= n_frames;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_JUMP_MAX:     r_jump_max <= i_cfg_wdata[7:0];
                    CFG_MIN_EXPECTED: r_min_exp  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= s_axis_tuser;
            r_src    <= s_axis_tdata[7:0];
            r_seq    <= s_axis_tdata[15:8];
        end
        if (r_state == S_UPD) begin
            r_gap <= n_gap;
        end
        if (r_state == S_MUL) begin
            r_expected <= w_expected;
            r_prod     <= DVD_W'(r_lost) * DVD_W'(PERMILLE_MAX);
            r_rate_en  <= (w_expected != '0) && (w_expected >= CNT_W'(r_min_exp));
        end
        if (w_load) begin
            r_out_gap      <= r_gap;
            r_out_lost     <= r_lost;
            r_out_frames   <= r_frames;
            r_out_expected <= r_expected;
            r_out_permille <= w_permille;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_permille, r_out_expected, r_out_frames,
                            r_out_lost, r_out_gap};

    `PSLT_ASSERT(a_permille_range, m_axis_tvalid |-> (r_out_permille <= PERMILLE_MAX))
    `PSLT_ASSERT(a_expected_covers_lost, m_axis_tvalid |-> (r_out_expected >= r_out_lost))
    `PSLT_ASSERT(a_div_done_in_wait, w_div_done |-> (r_state == S_DIV_WAIT))
    `PSLT_ASSERT_NEXT(a_accept_to_update, w_accept, r_state == S_UPD)

endmodule
